/* rtl/mrpt_pkg.sv */
// Shared types and constants for the Miller-Rabin prime tester.
package mrpt_pkg;
  localparam int unsigned NW = 63;
  localparam int unsigned MAX_BASES = 12;
  localparam int unsigned RW = 6;

  typedef enum logic [1:0] {
    CLS_COMPOSITE,
    CLS_PRIME,
    CLS_TEST
  } cls_t;

  // front-to-back queue entry
  typedef struct packed {
    cls_t          cls;
    logic [NW-1:0] n;
    logic [NW-1:0] d;
    logic [RW-1:0] r;
  } job_t;

  function automatic logic [5:0] base_of(input logic [3:0] idx);
    logic [5:0] b;
    case (idx)
      4'd0: b = 6'd2;
      4'd1: b = 6'd3;
      4'd2: b = 6'd5;
      4'd3: b = 6'd7;
      4'd4: b = 6'd11;
      4'd5: b = 6'd13;
      4'd6: b = 6'd17;
      4'd7: b = 6'd19;
      4'd8: b = 6'd23;
      4'd9: b = 6'd29;
      4'd10: b = 6'd31;
      4'd11: b = 6'd37;
      default: b = 6'd37;
    endcase
    return b;
  endfunction
endpackage

/* rtl/mrpt_front.sv */
// Front end: classifies the candidate and strips factors of two from n-1.
module mrpt_front
  import mrpt_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [NW-1:0] n_in,
  output logic          job_valid,
  input  logic          job_ready,
  output job_t          job
);
  logic busy;
  logic done;
  job_t work;

  assign in_ready  = !busy;
  assign job_valid = busy && done;
  assign job = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (!busy) begin
      if (in_valid) begin
        busy   <= 1'b1;
        work.n <= n_in;
        work.r <= '0;
        if (n_in <= NW'(1)) begin
          work.cls <= CLS_COMPOSITE;
          done <= 1'b1;
        end else if (n_in == NW'(2)) begin
          work.cls <= CLS_PRIME;
          done <= 1'b1;
        end else if (!n_in[0]) begin
          work.cls <= CLS_COMPOSITE;
          done <= 1'b1;
        end else begin
          work.cls <= CLS_TEST;
          work.d   <= n_in - NW'(1);
          done <= 1'b0;
        end
      end
    end else if (!done) begin
      // one trailing zero per cycle
      if (work.d[0]) done <= 1'b1;
      else begin
        work.d <= work.d >> 1;
        work.r <= work.r + RW'(1);
      end
    end else if (job_ready) begin
      busy <= 1'b0;
      done <= 1'b0;
    end
  end
endmodule

/* rtl/mrpt_queue.sv */
// Two-entry queue between front and back.
module mrpt_queue
  import mrpt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);
  job_t mem [2];
  logic wp, rp;
  logic [1:0] count;
  logic wr_en, rd_en;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data  = mem[rp];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (wr_en) wp <= !wp;
      if (rd_en) rp <= !rp;
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end
endmodule

/* rtl/mrpt_mulmod.sv */
// Add-and-double modular multiplier, one multiplier bit per cycle.
module mrpt_mulmod
  import mrpt_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] a,
  input  logic [NW-1:0] b,
  input  logic [NW-1:0] m,
  output logic          busy,
  output logic [NW-1:0] p
);
  logic [NW-1:0] aa, bb, mm;
  logic [NW:0] s_acc, s_dbl;
  logic [NW-1:0] acc_next, dbl_next;

  always_comb begin
    s_acc = {1'b0, p} + {1'b0, aa};
    acc_next = (s_acc >= {1'b0, mm}) ? NW'(s_acc - {1'b0, mm}) : s_acc[NW-1:0];
    s_dbl = {aa, 1'b0};
    dbl_next = (s_dbl >= {1'b0, mm}) ? NW'(s_dbl - {1'b0, mm}) : s_dbl[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      aa <= a;
      bb <= b;
      mm <= m;
      p  <= '0;
    end else if (busy) begin
      if (bb == '0) busy <= 1'b0;
      else begin
        if (bb[0]) p <= acc_next;
        aa <= dbl_next;
        bb <= bb >> 1;
      end
    end
  end
endmodule

/* rtl/mrpt_back.sv */
// Back end: runs the strong probable-prime rounds over the fixed bases.
module mrpt_back
  import mrpt_pkg::*;
#(
  parameter int unsigned NUM_BASES = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic res_valid,
  input  logic res_ready,
  output logic res_prime
);
  localparam int unsigned NB = (NUM_BASES < 1) ? 1 :
                               (NUM_BASES > MAX_BASES) ? MAX_BASES : NUM_BASES;

  typedef enum logic [2:0] {
    S_IDLE, S_BASE, S_POW, S_POW_W, S_SQR, S_SQR_W, S_OUT
  } state_t;

  state_t state;
  logic [NW-1:0] n, d, e, x, a, nm1;
  logic [RW-1:0] r, j;
  logic [3:0] bi;
  logic pow_sq;          // in pow: 0 = acc*a pending, 1 = a*a pending
  logic mm_start, mm_busy;
  logic [NW-1:0] mm_a, mm_b, mm_p;
  logic [NW-1:0] base;

  assign base = NW'(base_of(bi));
  assign job_ready = (state == S_IDLE);
  assign res_valid = (state == S_OUT);

  mrpt_mulmod u_mul (
    .clk(clk), .rst(rst), .start(mm_start), .a(mm_a), .b(mm_b), .m(n),
    .busy(mm_busy), .p(mm_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mm_start <= 1'b0;
    end else begin
      mm_start <= 1'b0;
      case (state)
        S_IDLE: if (job_valid) begin
          n <= job.n; d <= job.d; r <= job.r;
          nm1 <= job.n - NW'(1);
          bi <= '0;
          if (job.cls == CLS_TEST) state <= S_BASE;
          else begin
            res_prime <= (job.cls == CLS_PRIME);
            state <= S_OUT;
          end
        end
        S_BASE: begin
          if (base >= n - NW'(2)) begin
            if (bi == 4'(NB - 1)) begin res_prime <= 1'b1; state <= S_OUT; end
            else bi <= bi + 4'd1;
          end else begin
            x <= NW'(1); a <= base; e <= d; pow_sq <= 1'b0;
            state <= S_POW;
          end
        end
        S_POW: begin
          if (e == '0) begin
            j <= RW'(1);
            if (x == NW'(1) || x == nm1) begin
              if (bi == 4'(NB - 1)) begin res_prime <= 1'b1; state <= S_OUT; end
              else begin bi <= bi + 4'd1; state <= S_BASE; end
            end else state <= S_SQR;
          end else if (!pow_sq && !e[0]) begin
            pow_sq <= 1'b1;
          end else begin
            mm_a <= pow_sq ? a : x;
            mm_b <= a;
            mm_start <= 1'b1;
            state <= S_POW_W;
          end
        end
        S_POW_W: if (!mm_start && !mm_busy) begin
          if (pow_sq) begin
            a <= mm_p; e <= e >> 1; pow_sq <= 1'b0;
          end else begin
            x <= mm_p; pow_sq <= 1'b1;
          end
          state <= S_POW;
        end
        S_SQR: begin
          if (j >= r) begin res_prime <= 1'b0; state <= S_OUT; end
          else begin
            mm_a <= x; mm_b <= x; mm_start <= 1'b1; state <= S_SQR_W;
          end
        end
        S_SQR_W: if (!mm_start && !mm_busy) begin
          x <= mm_p;
          j <= j + RW'(1);
          if (mm_p == nm1) begin
            if (bi == 4'(NB - 1)) begin res_prime <= 1'b1; state <= S_OUT; end
            else begin bi <= bi + 4'd1; state <= S_BASE; end
          end else state <= S_SQR;
        end
        S_OUT: if (res_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/miller_rabin_prime_test.sv */
// Top level of the deterministic 63-bit Miller-Rabin prime tester.
//
//  channel | ports                      | payload
//  input   | in_valid / in_ready        | candidate[62:0]
//  output  | out_valid / out_ready      | is_prime
//
// Trivial candidates (0, 1, even) need no exponentiation; odd ones take
// up to NUM_BASES modular exponentiations of about 2*63 add-and-double multiplies,
// each handling one multiplier bit per cycle plus a hand-off.
// Reset is synchronous and clears all control state.
// The front strips n-1 while the back works; a two-entry queue decouples them.
// A stalled result parks the back; the queue fills, then in_ready drops.
module miller_rabin_prime_test
  import mrpt_pkg::*;
#(
  parameter int unsigned NUM_BASES = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [NW-1:0] candidate,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          is_prime
);
  logic f_valid, f_ready, q_valid, q_ready;
  job_t f_job, q_job;

  mrpt_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .n_in(candidate), .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  mrpt_queue u_queue (
    .clk(clk), .rst(rst), .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_data(f_job), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
  );

  mrpt_back #(.NUM_BASES(NUM_BASES)) u_back (
    .clk(clk), .rst(rst), .job_valid(q_valid), .job_ready(q_ready),
    .job(q_job), .res_valid(out_valid), .res_ready(out_ready),
    .res_prime(is_prime)
  );

`ifndef SYNTHESIS
  // an even candidate above 2 is never reported prime by the front
  a_even: assert property (@(posedge clk) disable iff (rst)
    (f_valid && !f_job.n[0] && f_job.n != NW'(2)) |-> f_job.cls == CLS_COMPOSITE)
    else $error("even candidate misclassified");
  // jobs sent for testing carry an odd d
  a_odd_d: assert property (@(posedge clk) disable iff (rst)
    (f_valid && f_job.cls == CLS_TEST) |-> f_job.d[0])
    else $error("d not odd");
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(is_prime)))
    else $error("result dropped");
`endif
endmodule
